>>> src/gn4_pkg.sv
`timescale 1ns / 1ps
package gn4_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int FRAC_BITS   = 16;
    localparam int COORD_W     = 24;
    localparam int WORK_BITS   = 24;
    localparam int GRAD_W      = 5;
    localparam int NUM_DIMS    = 4;
    localparam int NUM_CORNERS = 16;
    localparam int OFF_W       = WORK_BITS + 1;
    localparam int VAL_W       = WORK_BITS + 3;
    localparam int MA_W        = WORK_BITS + 5;
    localparam int MB_W        = WORK_BITS + 1;
    localparam int PROD_W      = MA_W + MB_W;
    localparam int OUT_W       = 19;
    localparam int OUT_LIMIT   = 196608;
    localparam int RND_W       = VAL_W + 1;
    localparam int SHR_W       = RND_W - (WORK_BITS - 16);

    localparam int CNT_W       = 4;
    localparam int SUB_W       = 3;
    localparam logic [SUB_W-1:0] HASH_LAST_SUB = 3'd4;
    localparam logic [CNT_W-1:0] PAIR_LAST     = 4'd7;
    localparam logic [SUB_W-1:0] FADE_LAST_SUB = 3'd3;
    localparam logic [CNT_W-1:0] DIM_LAST      = 4'd3;
    localparam logic [SUB_W-1:0] MIX_LAST_SUB  = 3'd1;
    localparam logic [CNT_W-1:0] MIX_LAST      = 4'd14;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_FADE,
        ST_MIX,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_WRITE,
        OP_HASH,
        OP_FADE,
        OP_MIX,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [CNT_W-1:0] idx;
        logic [SUB_W-1:0] sub;
    } cmd_t;

    // Per dimension: 2'b01 plus, 2'b11 minus, 2'b00 zero.
    function automatic logic [NUM_DIMS-1:0][1:0] grad_vec(input logic [GRAD_W-1:0] code);
        logic [NUM_DIMS-1:0][1:0] g;
        logic [1:0] zero_dim;
        logic [1:0] k;
        zero_dim = 2'd3 - code[1:0];
        for (int d = 0; d < NUM_DIMS; d++)
        begin
            k = (2'(d) < zero_dim) ? 2'(d) : 2'(d - 1);
            if (2'(d) == zero_dim)
            begin
                g[d] = 2'b00;
            end
            else
            begin
                g[d] = code[3'd4 - {1'b0, k}] ? 2'b11 : 2'b01;
            end
        end
        return g;
    endfunction

endpackage

>>> src/gn4_ram.sv
`timescale 1ns / 1ps
module gn4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

>>> src/gn4_dp.sv
`timescale 1ns / 1ps
module gn4_dp (
    input  logic                           clk,
    input  gn4_pkg::cmd_t                  cmd,
    input  logic [gn4_pkg::COORD_W-1:0]    coord_x,
    input  logic [gn4_pkg::COORD_W-1:0]    coord_y,
    input  logic [gn4_pkg::COORD_W-1:0]    coord_z,
    input  logic [gn4_pkg::COORD_W-1:0]    coord_t,
    input  logic [gn4_pkg::IDX_W-1:0]      entry_index,
    input  logic [7:0]                     entry_value,
    output logic signed [gn4_pkg::OUT_W-1:0] noise_value
);
    import gn4_pkg::*;

    logic [IDX_W-1:0]            cell_reg [NUM_DIMS];
    logic [WORK_BITS-1:0]        frac_reg [NUM_DIMS];
    logic [WORK_BITS-1:0]        w_reg    [NUM_DIMS];
    logic signed [VAL_W-1:0]     val_reg  [NUM_CORNERS];
    logic [WORK_BITS-1:0]        t2_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [OUT_W-1:0]     noise_reg;

    logic [COORD_W-1:0]          coord [NUM_DIMS];
    logic [IDX_W-1:0]            addr_a, addr_b;
    logic [7:0]                  rdata_a, rdata_b;
    logic [1:0]                  dim;
    logic [3:0]                  corner_a, corner_b;
    logic                        bit_a, bit_b;
    logic [IDX_W-1:0]            link_a, link_b;
    logic signed [VAL_W-1:0]     dot_a, dot_b;
    logic signed [MA_W-1:0]      mul_a;
    logic signed [MB_W-1:0]      mul_b;
    logic [WORK_BITS-1:0]        u;
    logic [WORK_BITS-1:0]        prod_mid;
    logic [MA_W-1:0]             poly;
    logic [1:0]                  wsel;
    logic [3:0]                  tail;
    logic signed [VAL_W:0]       diff;
    logic signed [VAL_W-1:0]     mix_res;
    logic signed [RND_W-1:0]     rnd;
    logic signed [SHR_W-1:0]     shr;
    logic signed [OUT_W-1:0]     clamped;

    function automatic logic signed [VAL_W-1:0] corner_dot(
        input logic [GRAD_W-1:0]   code,
        input logic [3:0]          corner,
        input logic [WORK_BITS-1:0] f0,
        input logic [WORK_BITS-1:0] f1,
        input logic [WORK_BITS-1:0] f2,
        input logic [WORK_BITS-1:0] f3
    );
        logic [NUM_DIMS-1:0][1:0]  g;
        logic [WORK_BITS-1:0]      f [NUM_DIMS];
        logic signed [OFF_W-1:0]   off;
        logic signed [VAL_W-1:0]   sum;
        g = grad_vec(code);
        f[0] = f0;
        f[1] = f1;
        f[2] = f2;
        f[3] = f3;
        sum = '0;
        for (int d = 0; d < NUM_DIMS; d++)
        begin
            off = $signed({1'b0, f[d]});
            if (corner[3-d])
            begin
                off = off - $signed({1'b1, {WORK_BITS{1'b0}}});
            end
            if (g[d] == 2'b01)
            begin
                sum = sum + VAL_W'(off);
            end
            else if (g[d] == 2'b11)
            begin
                sum = sum - VAL_W'(off);
            end
        end
        return sum;
    endfunction

    assign coord[0] = coord_x;
    assign coord[1] = coord_y;
    assign coord[2] = coord_z;
    assign coord[3] = coord_t;

    // Corner walk: two corners at a time that differ only in the fourth axis.
    assign dim      = cmd.sub[1:0];
    assign corner_a = {cmd.idx[2:0], 1'b0};
    assign corner_b = {cmd.idx[2:0], 1'b1};
    assign bit_a    = corner_a[2'd3 - dim];
    assign bit_b    = corner_b[2'd3 - dim];
    assign link_a   = (cmd.sub == '0) ? '0 : rdata_a;
    assign link_b   = (cmd.sub == '0) ? '0 : rdata_b;
    assign addr_a   = cell_reg[dim] + IDX_W'(bit_a) + link_a;
    assign addr_b   = cell_reg[dim] + IDX_W'(bit_b) + link_b;

    assign dot_a = corner_dot(rdata_a[GRAD_W-1:0], corner_a,
                              frac_reg[0], frac_reg[1], frac_reg[2], frac_reg[3]);
    assign dot_b = corner_dot(rdata_b[GRAD_W-1:0], corner_b,
                              frac_reg[0], frac_reg[1], frac_reg[2], frac_reg[3]);

    gn4_ram #(
        .WIDTH(8),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .we      (cmd.op == OP_WRITE),
        .waddr   (entry_index),
        .wdata   (entry_value),
        .raddr_a (addr_a),
        .raddr_b (addr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // Shared multiplier operands for fade and mix.
    assign u        = frac_reg[cmd.idx[1:0]];
    assign prod_mid = prod_reg[2*WORK_BITS-1:WORK_BITS];
    assign poly     = MA_W'({t2_reg, 2'b00}) + MA_W'({t2_reg, 1'b0})
                    + MA_W'(10 << WORK_BITS)
                    - (MA_W'({u, 4'b0000}) - MA_W'(u));

    always_comb
    begin
        if (cmd.idx < 4'd8)
        begin
            wsel = 2'd3;
        end
        else if (cmd.idx < 4'd12)
        begin
            wsel = 2'd2;
        end
        else if (cmd.idx < 4'd14)
        begin
            wsel = 2'd1;
        end
        else
        begin
            wsel = 2'd0;
        end
    end

    assign tail    = MIX_LAST - cmd.idx;
    assign diff    = {val_reg[1][VAL_W-1], val_reg[1]} - {val_reg[0][VAL_W-1], val_reg[0]};
    assign mix_res = val_reg[0] + VAL_W'(prod_reg[PROD_W-1:WORK_BITS]);

    always_comb
    begin
        mul_a = $signed({{(MA_W-WORK_BITS){1'b0}}, u});
        mul_b = $signed({1'b0, u});
        case (cmd.op)
            OP_FADE:
            begin
                case (cmd.sub)
                    3'd1:
                    begin
                        mul_a = $signed({{(MA_W-WORK_BITS){1'b0}}, prod_mid});
                    end
                    3'd2:
                    begin
                        mul_a = $signed(poly);
                        mul_b = $signed({1'b0, prod_mid});
                    end
                    default:
                    begin
                        mul_a = $signed({{(MA_W-WORK_BITS){1'b0}}, u});
                    end
                endcase
            end
            OP_MIX:
            begin
                mul_a = MA_W'(diff);
                mul_b = $signed({1'b0, w_reg[wsel]});
            end
            default:
            begin
                mul_a = $signed({{(MA_W-WORK_BITS){1'b0}}, u});
            end
        endcase
    end

    // Round Q.24 to Q.16 and clamp.
    assign rnd = {val_reg[0][VAL_W-1], val_reg[0]} + RND_W'(128);
    assign shr = rnd[RND_W-1:WORK_BITS-16];
    always_comb
    begin
        if (shr > SHR_W'(OUT_LIMIT))
        begin
            clamped = OUT_W'(OUT_LIMIT);
        end
        else if (shr < -SHR_W'(OUT_LIMIT))
        begin
            clamped = -OUT_W'(OUT_LIMIT);
        end
        else
        begin
            clamped = OUT_W'(shr);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (cmd.op)
            OP_CAPTURE:
            begin
                for (int d = 0; d < NUM_DIMS; d++)
                begin
                    cell_reg[d] <= IDX_W'({8'd0, coord[d]} >> FRAC_BITS);
                    frac_reg[d] <= WORK_BITS'({8'd0, coord[d]} << (WORK_BITS - FRAC_BITS));
                end
            end
            OP_HASH:
            begin
                if (cmd.sub == HASH_LAST_SUB)
                begin
                    val_reg[corner_a] <= dot_a;
                    val_reg[corner_b] <= dot_b;
                end
            end
            OP_FADE:
            begin
                if (cmd.sub == 3'd1)
                begin
                    t2_reg <= prod_mid;
                end
                if (cmd.sub == FADE_LAST_SUB)
                begin
                    w_reg[cmd.idx[1:0]] <= prod_mid;
                end
            end
            OP_MIX:
            begin
                // Drop the two consumed values and append the blend at the tail.
                if (cmd.sub == MIX_LAST_SUB)
                begin
                    for (int i = 0; i < NUM_CORNERS - 2; i++)
                    begin
                        val_reg[i] <= (CNT_W'(i) == tail) ? mix_res : val_reg[i+2];
                    end
                    if (tail == CNT_W'(NUM_CORNERS - 2))
                    begin
                        val_reg[NUM_CORNERS-2] <= mix_res;
                    end
                end
            end
            OP_EMIT:
            begin
                noise_reg <= clamped;
            end
            default:
            begin
            end
        endcase
    end

    assign noise_value = noise_reg;

endmodule

>>> src/gn4_ctrl.sv
`timescale 1ns / 1ps
module gn4_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          req_type,
    input  logic          out_ready,
    output logic          in_ready,
    output logic          out_valid,
    output gn4_pkg::cmd_t cmd
);
    import gn4_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [SUB_W-1:0] sub_reg, sub_next;
    logic             out_valid_reg, out_valid_next;
    logic             emit;

    assign emit = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        sub_next       = sub_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                sub_next = '0;
                if (in_valid && !req_type)
                begin
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                sub_next = sub_reg + 1'b1;
                if (sub_reg == HASH_LAST_SUB)
                begin
                    sub_next = '0;
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == PAIR_LAST)
                    begin
                        idx_next   = '0;
                        state_next = ST_FADE;
                    end
                end
            end
            ST_FADE:
            begin
                sub_next = sub_reg + 1'b1;
                if (sub_reg == FADE_LAST_SUB)
                begin
                    sub_next = '0;
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == DIM_LAST)
                    begin
                        idx_next   = '0;
                        state_next = ST_MIX;
                    end
                end
            end
            ST_MIX:
            begin
                sub_next = sub_reg + 1'b1;
                if (sub_reg == MIX_LAST_SUB)
                begin
                    sub_next = '0;
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == MIX_LAST)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd.op   = OP_NONE;
        cmd.idx  = idx_reg;
        cmd.sub  = sub_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = req_type ? OP_WRITE : OP_CAPTURE;
                end
            end
            ST_HASH:
            begin
                cmd.op = OP_HASH;
            end
            ST_FADE:
            begin
                cmd.op = OP_FADE;
            end
            ST_MIX:
            begin
                cmd.op = OP_MIX;
            end
            ST_DONE:
            begin
                cmd.op = emit ? OP_EMIT : OP_NONE;
            end
            default:
            begin
                cmd.op = OP_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            sub_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            sub_reg       <= sub_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> src/gradient_noise_4d.sv
`timescale 1ns / 1ps
// 4D gradient noise over a 256-entry hash table, signed Q2.16 result.
// Input channel (in_valid/in_ready) carries one word per request:
//   req_type 1 writes entry_value into hash table entry entry_index; it
//   produces no result. Every entry must be loaded before it is read by an
//   evaluation.
//   req_type 0 evaluates noise at (coord_x, coord_y, coord_z, coord_t), each
//   unsigned Q8.16 with the integer part wrapping modulo 256.
// Output channel (out_valid/out_ready) carries noise_value, one word per
// evaluation, held in an output register.
// An evaluation runs from acceptance to out_valid in steps: the chained table
// reads (two corners at a time on the two read ports), fade on one shared
// multiplier, blends on the same multiplier, and a final round.
// One evaluation is in flight at a time; in_ready is high only when idle, so
// loads are taken at one per cycle only while no evaluation is in flight.
// A stalled receiver holds the finished word; the block takes the next word
// meanwhile and waits before replacing the held result.
// Reset clears the control state and drops any pending result; table
// contents are kept as they are.
module gradient_noise_4d (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               req_type,
    input  logic [gn4_pkg::COORD_W-1:0]        coord_x,
    input  logic [gn4_pkg::COORD_W-1:0]        coord_y,
    input  logic [gn4_pkg::COORD_W-1:0]        coord_z,
    input  logic [gn4_pkg::COORD_W-1:0]        coord_t,
    input  logic [gn4_pkg::IDX_W-1:0]          entry_index,
    input  logic [7:0]                         entry_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [gn4_pkg::OUT_W-1:0]   noise_value
);
    import gn4_pkg::*;

    cmd_t cmd;

    gn4_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .req_type  (req_type),
        .out_ready (out_ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    gn4_dp u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .coord_t     (coord_t),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .noise_value (noise_value)
    );

`ifndef ASSERT_OFF
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !req_type |=> !in_ready)
        else $error("evaluation accepted but block still ready");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && req_type |=> in_ready)
        else $error("table load left the block busy");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without an evaluation in progress");
`endif

endmodule

>>> tb/tb_gradient_noise_4d.sv
`timescale 1ns / 1ps
module tb_gradient_noise_4d;
    import gn4_pkg::*;

    localparam logic REQ_EVAL = 1'b0;
    localparam logic REQ_LOAD = 1'b1;
    localparam longint ONE_W = 64'sd1 << WORK_BITS;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic                      req_type;
    logic [COORD_W-1:0]        coord_x;
    logic [COORD_W-1:0]        coord_y;
    logic [COORD_W-1:0]        coord_z;
    logic [COORD_W-1:0]        coord_t;
    logic [IDX_W-1:0]          entry_index;
    logic [7:0]                entry_value;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [OUT_W-1:0]   noise_value;

    logic [7:0]                perm[TABLE_DEPTH];
    logic signed [OUT_W-1:0]   noise_q[$];
    int                        err_count;
    int                        send_idle_pct;
    int                        recv_stall_pct;

    gradient_noise_4d u_top (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .coord_x(coord_x), .coord_y(coord_y),
        .coord_z(coord_z), .coord_t(coord_t), .entry_index(entry_index),
        .entry_value(entry_value), .out_valid(out_valid), .out_ready(out_ready),
        .noise_value(noise_value)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint floor_sh(input longint v, input int n);
        return v >>> n;
    endfunction

    function automatic longint fade_q24(input longint t);
        longint t2;
        longint t3;
        longint p;
        t2 = (t * t) >>> WORK_BITS;
        t3 = (t2 * t) >>> WORK_BITS;
        p = 6 * t2 + 10 * ONE_W - 15 * t;
        return (t3 * p) >>> WORK_BITS;
    endfunction

    // Sign of gradient component d for hash code h.
    function automatic int grad_sign(input logic [4:0] h, input int d);
        int zero_dim;
        int k;
        int bit_pos;
        zero_dim = 3 - int'(h[1:0]);
        if (d == zero_dim)
            return 0;
        k = (d < zero_dim) ? d : d - 1;
        bit_pos = 4 - k;
        return h[bit_pos] ? -1 : 1;
    endfunction

    function automatic logic signed [OUT_W-1:0] predict_noise(
        input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
        input logic [COORD_W-1:0] cz, input logic [COORD_W-1:0] ct);
        logic [COORD_W-1:0] cc[4];
        logic [7:0] cellv[4];
        longint fr[4];
        longint wt[4];
        longint val[16];
        longint s;
        longint r;
        logic [7:0] h;
        int n;
        int b;
        cc[0] = cx; cc[1] = cy; cc[2] = cz; cc[3] = ct;
        for (int d = 0; d < 4; d++)
        begin
            cellv[d] = cc[d][COORD_W-1:FRAC_BITS];
            fr[d] = longint'(cc[d][FRAC_BITS-1:0]) << (WORK_BITS - FRAC_BITS);
            wt[d] = fade_q24(fr[d]);
        end
        for (int c = 0; c < 16; c++)
        begin
            h = perm[8'(cellv[0] + 8'((c >> 3) & 1))];
            h = perm[8'(h + cellv[1] + 8'((c >> 2) & 1))];
            h = perm[8'(h + cellv[2] + 8'((c >> 1) & 1))];
            h = perm[8'(h + cellv[3] + 8'(c & 1))];
            s = 0;
            for (int d = 0; d < 4; d++)
            begin
                b = (c >> (3 - d)) & 1;
                s += grad_sign(h[4:0], d) * (fr[d] - (b ? ONE_W : 0));
            end
            val[c] = s;
        end
        n = 16;
        for (int st = 3; st >= 0; st--)
        begin
            for (int c = 0; c < n / 2; c++)
                val[c] = val[2*c] + floor_sh((val[2*c+1] - val[2*c]) * wt[st], WORK_BITS);
            n /= 2;
        end
        r = floor_sh(val[0] + 128, WORK_BITS - 16);
        if (r > OUT_LIMIT)
            r = OUT_LIMIT;
        if (r < -OUT_LIMIT)
            r = -OUT_LIMIT;
        return OUT_W'(r);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic send_word(input logic rt, input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
        input logic [COORD_W-1:0] t, input logic [7:0] idx, input logic [7:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rt;
        coord_x <= x; coord_y <= y; coord_z <= z; coord_t <= t;
        entry_index <= idx;
        entry_value <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (rt == REQ_LOAD)
            perm[idx] = v;
        else
            noise_q.push_back(predict_noise(x, y, z, t));
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (noise_q.size() == 0)
                report_mismatch($sformatf("unexpected noise_value %0d", noise_value));
            else
            begin
                if (noise_value !== noise_q[0])
                    report_mismatch($sformatf("noise_value %0d, want %0d",
                                              noise_value, noise_q[0]));
                void'(noise_q.pop_front());
            end
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return {8'($urandom), 16'h0000};
            3: return {8'($urandom), 16'hffff};
            default: return COORD_W'($urandom);
        endcase
    endfunction

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (noise_q.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic test_load_table();
        int order[TABLE_DEPTH];
        int j;
        int tmp;
        for (int i = 0; i < TABLE_DEPTH; i++)
            order[i] = i;
        for (int i = TABLE_DEPTH - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            tmp = order[i]; order[i] = order[j]; order[j] = tmp;
        end
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_word(REQ_LOAD, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                      COORD_W'($urandom), 8'(i), 8'(order[i]));
    endtask

    task automatic test_directed();
        send_word(REQ_EVAL, '0, '0, '0, '0, 8'hff, 8'hff);
        send_word(REQ_EVAL, '1, '1, '1, '1, 8'h00, 8'h00);
        send_word(REQ_EVAL, 24'h008000, 24'h008000, 24'h008000, 24'h008000, 8'h5a, 8'ha5);
        send_word(REQ_EVAL, 24'hff0001, 24'h00ffff, 24'h7f8000, 24'h80c000, 8'h00, 8'h00);
        send_word(REQ_EVAL, 24'h000001, 24'hffffff, 24'h000000, 24'hffffff, 8'h00, 8'h00);
        send_word(REQ_EVAL, 24'haaaaaa, 24'h555555, 24'haaaaaa, 24'h555555, 8'h00, 8'h00);
        // overwrite two entries with the extremes, then evaluate through them
        send_word(REQ_LOAD, '1, '1, '1, '1, 8'h00, 8'hff);
        send_word(REQ_LOAD, '0, '0, '0, '0, 8'hff, 8'h00);
        send_word(REQ_EVAL, 24'h004000, 24'hffc000, 24'h010000, 24'hfe0000, 8'h00, 8'h00);
        send_word(REQ_EVAL, 24'hffffff, 24'h000000, 24'hffffff, 24'h000000, 8'h00, 8'h00);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9) == 0)
                send_word(REQ_LOAD, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                          8'($urandom), 8'($urandom));
            else
                send_word(REQ_EVAL, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                          8'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_pause();
        // hold off until every pending word has drained
        send_word(REQ_EVAL, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  8'h00, 8'h00);
        wait_drain();
        send_word(REQ_EVAL, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  8'h00, 8'h00);
    endtask

    initial
    begin
        err_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_EVAL;
        coord_x = '0; coord_y = '0; coord_z = '0; coord_t = '0;
        entry_index = '0;
        entry_value = '0;
        out_ready = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_load_table();
        test_directed();
        test_random(200);
        test_pause();
        send_idle_pct = 74;
        test_random(150);
        send_idle_pct = 0;
        recv_stall_pct = 74;
        test_random(150);
        send_idle_pct = 7;
        recv_stall_pct = 7;
        test_random(200);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(50);
        wait_drain();
        if (err_count == 0)
            $display("gradient_noise_4d test passed");
        else
            $display("gradient_noise_4d test failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("gradient_noise_4d test failed");
        $finish;
    end
endmodule

>>> filelist.f
src/gn4_pkg.sv
src/gn4_ram.sv
src/gn4_dp.sv
src/gn4_ctrl.sv
src/gradient_noise_4d.sv
tb/tb_gradient_noise_4d.sv
